// ===== design/gtd_pkg.sv =====
// Package for the gravity tilt detector: widths, register reset values,
// configuration register indexes and axis codes.
// No dependencies.
package gtd_pkg;

  // Field widths
  localparam int ACCEL_W    = 16;
  localparam int TIME_W     = 16;
  localparam int PERIOD_W   = 10;
  localparam int WEIGHT_W   = 17;
  localparam int THRESH_W   = 15;
  localparam int AXIS_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  // Filter weight is Q16: 65536 stands for one
  localparam int WEIGHT_SHIFT = 16;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(65536);

  // Default number of fraction bits in the gravity estimate
  localparam int FRACTION_BITS_DEF = 16;

  // Register values after reset
  localparam logic                SENSOR_AVAILABLE_RST  = 1'b1;
  localparam logic [AXIS_W-1:0]   UP_AXIS_RST           = '0;
  localparam logic [PERIOD_W-1:0] READ_PERIOD_MS_RST    = PERIOD_W'(20);
  localparam logic [WEIGHT_W-1:0] FILTER_WEIGHT_RST     = WEIGHT_W'(13107);
  localparam logic [THRESH_W-1:0] UPRIGHT_THRESHOLD_RST = THRESH_W'(6554);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SENSOR_AVAILABLE  = 3'd0,
    CFG_UP_AXIS           = 3'd1,
    CFG_READ_PERIOD_MS    = 3'd2,
    CFG_FILTER_WEIGHT     = 3'd3,
    CFG_UPRIGHT_THRESHOLD = 3'd4
  } cfg_reg_t;

  // Signed axis codes
  typedef enum logic [AXIS_W-1:0] {
    AXIS_NONE  = 3'd0,
    AXIS_POS_X = 3'd1,
    AXIS_NEG_X = 3'd2,
    AXIS_POS_Y = 3'd3,
    AXIS_NEG_Y = 3'd4,
    AXIS_POS_Z = 3'd5,
    AXIS_NEG_Z = 3'd6
  } axis_t;

endpackage

// ===== design/gravity_tilt_detector.sv =====
// Gravity tilt detector top level: sample gating, EMA gravity filter and
// axis/upright evaluation. Depends on gtd_pkg.
//
// The block takes one item per clock unless the output stalls, and returns one
// result per item via the stage and result registers. The elapsed-time
// counter, the read-period gate and the exponential moving average (one signed
// multiply by the Q16 weight per axis) are all resolved in the cycle the item
// is accepted, so the next item sees the updated estimate right away; that
// multiply-and-add loop through the estimate registers sets the
// one-item-per-cycle figure. The following stage picks the dominant signed
// axis and checks the up axis against the threshold. The gravity estimate
// holds FRACTION_BITS fraction bits; the gravity outputs are its floor in
// whole counts. The user must write configuration through cfg_wr_en, cfg_index
// and cfg_wdata only while no item is in flight; the block does not check.
module gravity_tilt_detector #(
  parameter int FRACTION_BITS = gtd_pkg::FRACTION_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration write port
  input  logic                                cfg_wr_en,
  input  logic [gtd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [gtd_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  // input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [gtd_pkg::TIME_W-1:0]          in_elapsed_ms,
  input  logic                                in_read_ok,
  input  logic signed [gtd_pkg::ACCEL_W-1:0]  in_accel_x,
  input  logic signed [gtd_pkg::ACCEL_W-1:0]  in_accel_y,
  input  logic signed [gtd_pkg::ACCEL_W-1:0]  in_accel_z,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_sample_taken,
  output logic [gtd_pkg::AXIS_W-1:0]          out_dominant_axis,
  output logic                                out_upright,
  output logic                                out_can_deploy,
  output logic signed [gtd_pkg::ACCEL_W-1:0]  out_gravity_est_x,
  output logic signed [gtd_pkg::ACCEL_W-1:0]  out_gravity_est_y,
  output logic signed [gtd_pkg::ACCEL_W-1:0]  out_gravity_est_z
);

  localparam int EST_W  = gtd_pkg::ACCEL_W + FRACTION_BITS;
  localparam int DIFF_W = EST_W + 1;
  localparam int PROD_W = DIFF_W + gtd_pkg::WEIGHT_W + 1;
  localparam int NAXIS  = 3;

  // ---------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------
  logic                              sensor_available_r;
  logic [gtd_pkg::AXIS_W-1:0]        up_axis_r;
  logic [gtd_pkg::PERIOD_W-1:0]      read_period_ms_r;
  logic [gtd_pkg::WEIGHT_W-1:0]      filter_weight_r;
  logic [gtd_pkg::THRESH_W-1:0]      upright_threshold_r;

  // Write the addressed register; ignore indexes past the list
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sensor_available_r  <= gtd_pkg::SENSOR_AVAILABLE_RST;
      up_axis_r           <= gtd_pkg::UP_AXIS_RST;
      read_period_ms_r    <= gtd_pkg::READ_PERIOD_MS_RST;
      filter_weight_r     <= gtd_pkg::FILTER_WEIGHT_RST;
      upright_threshold_r <= gtd_pkg::UPRIGHT_THRESHOLD_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        gtd_pkg::CFG_SENSOR_AVAILABLE:  sensor_available_r  <= cfg_wdata[0];
        gtd_pkg::CFG_UP_AXIS:           up_axis_r           <= cfg_wdata[gtd_pkg::AXIS_W-1:0];
        gtd_pkg::CFG_READ_PERIOD_MS:    read_period_ms_r    <= cfg_wdata[gtd_pkg::PERIOD_W-1:0];
        gtd_pkg::CFG_FILTER_WEIGHT:     filter_weight_r     <= cfg_wdata[gtd_pkg::WEIGHT_W-1:0];
        gtd_pkg::CFG_UPRIGHT_THRESHOLD: upright_threshold_r <= cfg_wdata[gtd_pkg::THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------
  // Handshake and pipeline control
  // ---------------------------------------------------------------
  logic s1_valid_r, s1_valid_nxt;
  logic out_valid_r;
  logic advance;
  logic in_fire;

  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || advance;
  assign in_fire  = in_valid && in_ready;

  // ---------------------------------------------------------------
  // Accept stage: time gate and filter update
  // ---------------------------------------------------------------
  logic [gtd_pkg::TIME_W-1:0]   time_r, time_nxt;
  logic                         have_r, have_nxt;
  logic signed [EST_W-1:0]      est_r   [NAXIS];
  logic signed [EST_W-1:0]      est_nxt [NAXIS];
  logic signed [gtd_pkg::ACCEL_W-1:0] accel [NAXIS];

  logic [gtd_pkg::TIME_W:0]     time_sum;
  logic [gtd_pkg::TIME_W-1:0]   time_sat;
  logic                         period_hit;
  logic                         sample;
  logic [gtd_pkg::WEIGHT_W-1:0] weight;

  assign accel[0] = in_accel_x;
  assign accel[1] = in_accel_y;
  assign accel[2] = in_accel_z;

  // Saturating elapsed-time sum and read-period gate
  assign time_sum   = {1'b0, time_r} + {1'b0, in_elapsed_ms};
  assign time_sat   = time_sum[gtd_pkg::TIME_W] ? '1 : time_sum[gtd_pkg::TIME_W-1:0];
  assign period_hit = time_sat >= {{(gtd_pkg::TIME_W-gtd_pkg::PERIOD_W){1'b0}}, read_period_ms_r};
  assign sample     = sensor_available_r && period_hit && in_read_ok;

  // Clamp weight to one
  assign weight = (filter_weight_r > gtd_pkg::WEIGHT_ONE) ? gtd_pkg::WEIGHT_ONE
                                                          : filter_weight_r;

  always_comb begin
    time_nxt = time_r;
    if (sensor_available_r) begin
      time_nxt = period_hit ? '0 : time_sat;
    end
  end

  assign have_nxt = have_r || sample;

  // One EMA lane per axis: the first sample loads est, later ones do est += floor(w * (sample - est) / 2^16)
  for (genvar a = 0; a < NAXIS; a++) begin : g_lane
    logic signed [EST_W-1:0]  fix;
    logic signed [DIFF_W-1:0] diff;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] delta;
    logic signed [DIFF_W-1:0] step;

    assign fix   = {accel[a], {FRACTION_BITS{1'b0}}};
    assign diff  = $signed({fix[EST_W-1], fix}) - $signed({est_r[a][EST_W-1], est_r[a]});
    assign prod  = PROD_W'(diff) * PROD_W'($signed({1'b0, weight}));
    assign delta = prod >>> gtd_pkg::WEIGHT_SHIFT;
    assign step  = $signed({est_r[a][EST_W-1], est_r[a]}) + delta[DIFF_W-1:0];

    always_comb begin
      est_nxt[a] = est_r[a];
      if (sample) begin
        est_nxt[a] = have_r ? step[EST_W-1:0] : fix;
      end
    end
  end

  // Update state on each accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r <= '0;
      have_r <= 1'b0;
      for (int i = 0; i < NAXIS; i++) est_r[i] <= '0;
    end else if (in_fire) begin
      time_r <= time_nxt;
      have_r <= have_nxt;
      for (int i = 0; i < NAXIS; i++) est_r[i] <= est_nxt[i];
    end
  end

  // ---------------------------------------------------------------
  // Stage register: snapshot of the updated state for this item
  // ---------------------------------------------------------------
  logic                    s1_taken_r;
  logic                    s1_have_r;
  logic signed [EST_W-1:0] s1_est_r [NAXIS];

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // Hold snapshot payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_taken_r <= sample;
      s1_have_r  <= have_nxt;
      for (int i = 0; i < NAXIS; i++) s1_est_r[i] <= est_nxt[i];
    end
  end

  // ---------------------------------------------------------------
  // Evaluation: dominant axis, upright, deploy
  // ---------------------------------------------------------------
  logic signed [DIFF_W-1:0] along [6];
  logic signed [DIFF_W-1:0] along_up;
  logic signed [DIFF_W-1:0] thresh_fixed;
  gtd_pkg::axis_t           dominant;
  logic                     up_valid;
  logic                     upright;
  logic                     can_deploy;

  // Gravity along each signed axis, one bit wider so negation cannot wrap
  for (genvar a = 0; a < NAXIS; a++) begin : g_along
    assign along[2*a]   = $signed({s1_est_r[a][EST_W-1], s1_est_r[a]});
    assign along[2*a+1] = -$signed({s1_est_r[a][EST_W-1], s1_est_r[a]});
  end

  // Largest positive component; ties keep the lower code
  always_comb begin
    logic signed [DIFF_W-1:0] best_val;
    best_val = '0;
    dominant = gtd_pkg::AXIS_NONE;
    for (int i = 0; i < 6; i++) begin
      if (along[i] > best_val) begin
        best_val = along[i];
        dominant = gtd_pkg::axis_t'(3'(i + 1));
      end
    end
    if (!s1_have_r) begin
      dominant = gtd_pkg::AXIS_NONE;
    end
  end

  // Select the configured up axis; codes outside one to six mean none
  always_comb begin
    up_valid = 1'b1;
    along_up = '0;
    unique case (up_axis_r)
      gtd_pkg::AXIS_POS_X: along_up = along[0];
      gtd_pkg::AXIS_NEG_X: along_up = along[1];
      gtd_pkg::AXIS_POS_Y: along_up = along[2];
      gtd_pkg::AXIS_NEG_Y: along_up = along[3];
      gtd_pkg::AXIS_POS_Z: along_up = along[4];
      gtd_pkg::AXIS_NEG_Z: along_up = along[5];
      default:             up_valid = 1'b0;
    endcase
  end

  assign thresh_fixed = $signed({2'b00, upright_threshold_r, {FRACTION_BITS{1'b0}}});
  assign upright      = s1_have_r && up_valid && (along_up >= thresh_fixed);
  assign can_deploy   = !sensor_available_r || !s1_have_r || !up_valid || upright;

  // ---------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  // Load result payload when the result stage advances
  always_ff @(posedge clk) begin
    if (advance) begin
      out_sample_taken  <= s1_taken_r;
      out_dominant_axis <= dominant;
      out_upright       <= upright;
      out_can_deploy    <= can_deploy;
      out_gravity_est_x <= s1_est_r[0][EST_W-1 -: gtd_pkg::ACCEL_W];
      out_gravity_est_y <= s1_est_r[1][EST_W-1 -: gtd_pkg::ACCEL_W];
      out_gravity_est_z <= s1_est_r[2][EST_W-1 -: gtd_pkg::ACCEL_W];
    end
  end

  assign out_valid = out_valid_r;

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
  a_stall_means_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && out_valid_r))
    else $error("input stalled while the pipeline has room");

  a_taken_has_reading: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_taken_r) |-> s1_have_r)
    else $error("sample taken without a gravity reading");

  a_reading_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    have_r |=> have_r)
    else $error("gravity reading flag dropped");

  a_sample_clears_timer: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && sample) |=> (time_r == '0))
    else $error("elapsed-time counter not cleared after a sample");

  a_upright_deploys: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_upright) |-> out_can_deploy)
    else $error("upright result without deploy permission");

endmodule
